[sv/pcce_pkg.sv]
`default_nettype none
package pcce_pkg;

  localparam int DEF_POINT_CAPACITY = 65536;
  localparam int DEF_MAX_VERTS      = 8;

  localparam int COORD_W   = 32;
  localparam int MAP_W     = 17;
  localparam int CELL_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [COORD_W-1:0] NORMAL_Z_RESET = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X      = 3'd0,
    REG_NORMAL_Y      = 3'd1,
    REG_NORMAL_Z      = 3'd2,
    REG_ORIGIN_X      = 3'd3,
    REG_ORIGIN_Y      = 3'd4,
    REG_ORIGIN_Z      = 3'd5,
    REG_REMOVE_UNUSED = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_COMPACT = 2'd2,
    MODE_REMAP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VERTEX  = 2'd0,
    KIND_COMPACT = 2'd1,
    KIND_REMAP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_MANY  = 2'd1,
    ERR_NOT_LOADED = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CLASS_ON    = 2'd0,
    CLASS_BELOW = 2'd1,
    CLASS_ABOVE = 2'd2
  } class_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_VERT,
    S_EMIT,
    S_SWEEP,
    S_DONE,
    S_REMAP
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
  } plane_t;

endpackage
`default_nettype wire

[sv/pcce_if.sv]
`default_nettype none
interface pcce_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [15:0] vertex_id;
  logic [7:0]  cell_type;
  logic        vertex_last;

  modport source(output valid, mode, point_x, point_y, point_z, vertex_id, cell_type,
                 vertex_last, input ready);
  modport sink(input valid, mode, point_x, point_y, point_z, vertex_id, cell_type,
               vertex_last, output ready);
endinterface

interface pcce_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_point_id;
  logic [7:0]  out_cell_type;
  logic [23:0] source_cell;
  logic        point_used;
  logic [16:0] used_count;
  logic [1:0]  error;
  logic        last;

  modport source(output valid, kind, out_point_id, out_cell_type, source_cell, point_used,
                 used_count, error, last, input ready);
  modport sink(input valid, kind, out_point_id, out_cell_type, source_cell, point_used,
               used_count, error, last, output ready);
endinterface
`default_nettype wire

[sv/pcce_classify.sv]
`default_nettype none
module pcce_classify
  import pcce_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire plane_t                    plane,
  input  wire logic signed [COORD_W-1:0] px,
  input  wire logic signed [COORD_W-1:0] py,
  input  wire logic signed [COORD_W-1:0] pz,
  output logic                           done,
  output class_t                         cls
);

  logic                        v0, v1;
  logic signed [COORD_W:0]     dx, dy, dz;
  logic signed [COORD_W-1:0]   nx, ny, nz;
  logic signed [2*COORD_W:0]   mx, my, mz;
  logic signed [2*COORD_W+2:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start;
      v1   <= v0;
      done <= v1;
    end
  end

  // Exact sign of n.(p - o): 33-bit differences, 65-bit products, 67-bit sum.
  always_ff @(posedge clk) begin
    dx <= (COORD_W+1)'(px) - (COORD_W+1)'(plane.ox);
    dy <= (COORD_W+1)'(py) - (COORD_W+1)'(plane.oy);
    dz <= (COORD_W+1)'(pz) - (COORD_W+1)'(plane.oz);
    nx <= plane.nx;
    ny <= plane.ny;
    nz <= plane.nz;
    mx <= (2*COORD_W+1)'(nx) * (2*COORD_W+1)'(dx);
    my <= (2*COORD_W+1)'(ny) * (2*COORD_W+1)'(dy);
    mz <= (2*COORD_W+1)'(nz) * (2*COORD_W+1)'(dz);
  end

  always_comb begin
    sum = (2*COORD_W+3)'(mx) + (2*COORD_W+3)'(my) + (2*COORD_W+3)'(mz);
  end

  always_ff @(posedge clk) begin
    if (sum[2*COORD_W+2]) begin
      cls <= CLASS_BELOW;
    end else if (sum != '0) begin
      cls <= CLASS_ABOVE;
    end else begin
      cls <= CLASS_ON;
    end
  end

endmodule
`default_nettype wire

[sv/plane_crinkle_cell_extract.sv]
// Load word: a 3-stage exact plane test, then the class store write.
// Vertex word: the class store read, then the AND update; a cut cell then
// emits one vertex word per cycle while the output is free, up to MAX_VERTS.
// Compact word: a sweep over all POINT_CAPACITY entries, one mark read and map write per cycle.
// Remap word: a map read. After reset the mark memory is cleared, during
// which no word is taken.
`default_nettype none
module plane_crinkle_cell_extract
  import pcce_pkg::*;
#(
  parameter int POINT_CAPACITY = DEF_POINT_CAPACITY,
  parameter int MAX_VERTS      = DEF_MAX_VERTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  pcce_item_if.sink                 item,
  pcce_result_if.source             result,
  input  wire logic                 cfg_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(POINT_CAPACITY);
  localparam int PCW = AW + 1;
  localparam int VCW = $clog2(MAX_VERTS + 1);
  localparam int VIW = $clog2(MAX_VERTS);

  // Configuration
  plane_t plane;
  logic   remove_unused;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane.nx      <= '0;
      plane.ny      <= '0;
      plane.nz      <= NORMAL_Z_RESET;
      plane.ox      <= '0;
      plane.oy      <= '0;
      plane.oz      <= '0;
      remove_unused <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORMAL_X:      plane.nx <= cfg_data;
        REG_NORMAL_Y:      plane.ny <= cfg_data;
        REG_NORMAL_Z:      plane.nz <= cfg_data;
        REG_ORIGIN_X:      plane.ox <= cfg_data;
        REG_ORIGIN_Y:      plane.oy <= cfg_data;
        REG_ORIGIN_Z:      plane.oz <= cfg_data;
        REG_REMOVE_UNUSED: remove_unused <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memories
  logic [1:0]       class_mem [POINT_CAPACITY];
  logic             mark_mem  [POINT_CAPACITY];
  logic [MAP_W-1:0] map_mem   [POINT_CAPACITY];
  logic [1:0]       class_rd;
  logic             mark_rd;
  logic [MAP_W-1:0] map_rd;

  // Control state
  state_t            state, state_next;
  logic [PCW-1:0]    point_count;
  logic [PCW-1:0]    sweep_addr;
  logic [PCW-1:0]    next_id;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [VCW-1:0]    vertex_count;
  logic [VCW-1:0]    emit_k;
  logic [1:0]        side_and;
  logic [7:0]        held_type;
  logic [CELL_W-1:0] cell_index;
  logic [1:0]        cell_fault;
  logic              good_q, last_q, in_range_q;
  logic [15:0]       vbuf [MAX_VERTS];

  logic   cls_done;
  class_t cls;

  // Decoded actions
  logic             acc, out_free, out_load, cls_start, class_we;
  logic             mark_we, mark_wdata, map_we;
  logic [AW-1:0]    mark_waddr;
  logic [MAP_W-1:0] map_wdata;
  logic [1:0]       side_new;
  logic [15:0]      emit_v;
  logic             emit_last, v_over, v_bad, sweep_keep;

  pcce_classify u_classify (
    .clk   (clk),
    .rst   (rst),
    .start (cls_start),
    .plane (plane),
    .px    (item.point_x),
    .py    (item.point_y),
    .pz    (item.point_z),
    .done  (cls_done),
    .cls   (cls)
  );

  always_comb begin
    acc        = item.valid && item.ready;
    out_free   = !result.valid || result.ready;
    v_over     = vertex_count >= VCW'(MAX_VERTS);
    v_bad      = !v_over && (32'(item.vertex_id) >= 32'(point_count));
    side_new   = good_q ? (side_and & class_rd) : side_and;
    emit_v     = vbuf[emit_k[VIW-1:0]];
    emit_last  = (emit_k + VCW'(1)) == vertex_count;
    sweep_keep = (PCW'(pend_addr) < point_count) && mark_rd;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sweep_addr == PCW'(POINT_CAPACITY - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (item.valid) begin
          case (mode_t'(item.mode))
            MODE_LOAD:    state_next = cls_start ? S_LOAD : S_IDLE;
            MODE_VERTEX:  state_next = S_VERT;
            MODE_COMPACT: state_next = S_SWEEP;
            default:      state_next = S_REMAP;
          endcase
        end
      end
      S_LOAD: if (cls_done) state_next = S_IDLE;
      S_VERT: begin
        if (!last_q) begin
          state_next = S_IDLE;
        end else if (cell_fault != ERR_NONE) begin
          if (out_free) state_next = S_IDLE;
        end else if (side_new == 2'b00) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT:  if (out_free && emit_last) state_next = S_IDLE;
      S_SWEEP: if (!pend && sweep_addr == PCW'(POINT_CAPACITY)) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      S_REMAP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item.ready = state == S_IDLE;
    cls_start  = item.valid && (state == S_IDLE) && (mode_t'(item.mode) == MODE_LOAD) &&
                 (point_count < PCW'(POINT_CAPACITY));
    class_we   = (state == S_LOAD) && cls_done;
    mark_we    = 1'b0;
    mark_waddr = sweep_addr[AW-1:0];
    mark_wdata = 1'b0;
    map_we     = 1'b0;
    map_wdata  = sweep_keep ? {1'b1, 16'(next_id)} : '0;
    out_load   = 1'b0;
    case (state)
      S_CLEAR: mark_we = 1'b1;
      S_SWEEP: begin
        mark_we    = pend;
        mark_waddr = pend_addr;
        map_we     = pend;
      end
      S_EMIT: begin
        out_load   = out_free;
        mark_we    = out_free && remove_unused && (32'(emit_v) < 32'(POINT_CAPACITY));
        mark_waddr = AW'(emit_v);
        mark_wdata = 1'b1;
      end
      S_VERT:  out_load = last_q && (cell_fault != ERR_NONE) && out_free;
      S_DONE:  out_load = out_free;
      S_REMAP: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (class_we) class_mem[point_count[AW-1:0]] <= cls;
    if (acc) class_rd <= class_mem[AW'(item.vertex_id)];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    mark_rd <= mark_mem[sweep_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[pend_addr] <= map_wdata;
    if (acc) map_rd <= map_mem[AW'(item.vertex_id)];
  end

  always_ff @(posedge clk) begin
    if (acc && (mode_t'(item.mode) == MODE_VERTEX) && !v_over && !v_bad) begin
      vbuf[vertex_count[VIW-1:0]] <= item.vertex_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      point_count  <= '0;
      sweep_addr   <= '0;
      next_id      <= '0;
      pend         <= 1'b0;
      pend_addr    <= '0;
      vertex_count <= '0;
      emit_k       <= '0;
      side_and     <= 2'b11;
      held_type    <= '0;
      cell_index   <= '0;
      cell_fault   <= ERR_NONE;
      good_q       <= 1'b0;
      last_q       <= 1'b0;
      in_range_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) sweep_addr <= sweep_addr + PCW'(1);
      if (class_we) point_count <= point_count + PCW'(1);

      if (acc) begin
        case (mode_t'(item.mode))
          MODE_VERTEX: begin
            held_type <= item.cell_type;
            last_q    <= item.vertex_last;
            good_q    <= !v_over && !v_bad;
            if (v_over) begin
              if (cell_fault == ERR_NONE) cell_fault <= ERR_TOO_MANY;
            end else begin
              if (v_bad && cell_fault == ERR_NONE) cell_fault <= ERR_NOT_LOADED;
              vertex_count <= vertex_count + VCW'(1);
            end
          end
          MODE_COMPACT: begin
            sweep_addr   <= '0;
            next_id      <= '0;
            pend         <= 1'b0;
            cell_index   <= '0;
            vertex_count <= '0;
            side_and     <= 2'b11;
            held_type    <= '0;
            cell_fault   <= ERR_NONE;
          end
          MODE_REMAP: in_range_q <= 32'(item.vertex_id) < 32'(POINT_CAPACITY);
          default: ;
        endcase
      end

      // A finished cell advances the cell index and clears the cell state.
      if ((state == S_VERT && state_next == S_IDLE && last_q) ||
          (state == S_EMIT && out_free && emit_last)) begin
        cell_index   <= cell_index + CELL_W'(1);
        vertex_count <= '0;
        side_and     <= 2'b11;
        held_type    <= '0;
        cell_fault   <= ERR_NONE;
      end else if (state == S_VERT) begin
        side_and <= side_new;
        emit_k   <= '0;
      end
      if (state == S_EMIT && out_free) emit_k <= emit_k + VCW'(1);

      // The sweep reads one mark ahead of the entry it writes back.
      if (state == S_SWEEP) begin
        if (sweep_addr != PCW'(POINT_CAPACITY)) begin
          pend       <= 1'b1;
          pend_addr  <= sweep_addr[AW-1:0];
          sweep_addr <= sweep_addr + PCW'(1);
        end else begin
          pend <= 1'b0;
        end
        if (pend && sweep_keep) next_id <= next_id + PCW'(1);
      end
      if (state == S_DONE && out_free) point_count <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.kind          <= KIND_VERTEX;
      result.out_point_id  <= '0;
      result.out_cell_type <= '0;
      result.source_cell   <= '0;
      result.point_used    <= 1'b0;
      result.used_count    <= '0;
      result.error         <= ERR_NONE;
      result.last          <= 1'b1;
      case (state)
        S_VERT: begin
          result.out_cell_type <= held_type;
          result.source_cell   <= cell_index;
          result.error         <= cell_fault;
        end
        S_EMIT: begin
          result.out_point_id  <= emit_v;
          result.out_cell_type <= held_type;
          result.source_cell   <= cell_index;
          result.last          <= emit_last;
        end
        S_DONE: begin
          result.kind       <= KIND_COMPACT;
          result.used_count <= 17'(next_id);
        end
        S_REMAP: begin
          result.kind <= KIND_REMAP;
          if (in_range_q && map_rd[MAP_W-1]) begin
            result.point_used   <= 1'b1;
            result.out_point_id <= map_rd[15:0];
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_class_in_range: assert property (@(posedge clk) disable iff (rst)
    class_we |-> point_count < PCW'(POINT_CAPACITY))
    else $error("class written beyond capacity");
  a_emit_in_cell: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> emit_k < vertex_count && cell_fault == ERR_NONE)
    else $error("emission index outside cell");
  a_mark_needs_enable: assert property (@(posedge clk) disable iff (rst)
    (mark_we && mark_wdata) |-> remove_unused && state == S_EMIT)
    else $error("mark set without remove_unused");
  // A load into a full store is dropped and leaves the block idle.
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (acc && state_next != S_IDLE) |=> !item.ready)
    else $error("word taken while busy");
`endif

endmodule
`default_nettype wire
